// ===== sv/clse_pkg.sv =====
// Shared types, request codes, opcodes and sequencer states of the load/store executor.
package clse_pkg;

	localparam int MEM_ADDR_BITS_DEF = 16;

	// Request kinds carried on the input tuser
	localparam logic [1:0] REQ_WRITE  = 2'd0;
	localparam logic [1:0] REQ_SET_PC = 2'd1;
	localparam logic [1:0] REQ_EXEC   = 2'd2;

	// Supported opcodes
	localparam logic [7:0] OP_LDA_IMM = 8'hA9;
	localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
	localparam logic [7:0] OP_LDA_ZPX = 8'hB5;
	localparam logic [7:0] OP_LDA_ABS = 8'hAD;
	localparam logic [7:0] OP_LDA_ABX = 8'hBD;
	localparam logic [7:0] OP_LDA_ABY = 8'hB9;
	localparam logic [7:0] OP_LDA_INX = 8'hA1;
	localparam logic [7:0] OP_LDA_INY = 8'hB1;
	localparam logic [7:0] OP_LDX_IMM = 8'hA2;
	localparam logic [7:0] OP_LDY_IMM = 8'hA0;
	localparam logic [7:0] OP_STA_ZP  = 8'h85;
	localparam logic [7:0] OP_STX_ZP  = 8'h86;
	localparam logic [7:0] OP_STY_ZP  = 8'h84;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH_OP,
		ST_OPER1,
		ST_OPER2,
		ST_PTR_HI,
		ST_PTR_END,
		ST_LOAD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        we;
		logic [15:0] addr;
		logic [7:0]  wdata;
	} mem_req_t;

	typedef struct packed {
		logic [15:0] a;
		logic [15:0] b;
	} alu_in_t;

	typedef struct packed {
		logic [15:0] sum;
		logic        page_cross;
	} alu_out_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
	} seq_stat_t;

	typedef struct packed {
		logic [2:0]  cycles;
		logic [7:0]  acc;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [15:0] pc;
	} result_t;

endpackage

// ===== sv/clse_ram.sv =====
// Generic single-port RAM with registered read data.
module clse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/clse_alu.sv =====
// Shared 16-bit address adder with page-cross detection.
module clse_alu (
	input  clse_pkg::alu_in_t  op,
	output clse_pkg::alu_out_t res
);

	logic [16:0] sum;

	assign sum = {1'b0, op.a} + {1'b0, op.b};

	// The index operand never exceeds one byte, so a change of bit 8 relative
	// to the base means the low byte carried into the page.
	assign res.sum        = sum[15:0];
	assign res.page_cross = sum[8] ^ op.a[8];

endmodule

// ===== sv/clse_seq.sv =====
// Instruction sequencer: fetches, decodes and executes one request over several cycles.
module clse_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           req_type,
	input  logic [15:0]          address,
	input  logic [7:0]           write_byte,
	input  logic [7:0]           rdata,
	input  logic                 res_taken,
	output clse_pkg::mem_req_t   mem_req,
	output clse_pkg::seq_stat_t  stat,
	output clse_pkg::result_t    result
);

	clse_pkg::state_t   state_q, state_d;
	clse_pkg::alu_in_t  alu_in;
	clse_pkg::alu_out_t alu_out;

	logic [7:0]  acc_q, acc_d;
	logic [7:0]  x_q, x_d;
	logic [7:0]  y_q, y_d;
	logic [15:0] pc_q, pc_d;
	logic [7:0]  op_q, op_d;
	logic [7:0]  lo_q, lo_d;
	logic [2:0]  cyc_q, cyc_d;

	clse_alu u_alu (
		.op  (alu_in),
		.res (alu_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clse_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			x_q   <= '0;
			y_q   <= '0;
			pc_q  <= '0;
		end else begin
			acc_q <= acc_d;
			x_q   <= x_d;
			y_q   <= y_d;
			pc_q  <= pc_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q  <= op_d;
		lo_q  <= lo_d;
		cyc_q <= cyc_d;
	end

	always_comb begin
		state_d = state_q;
		acc_d   = acc_q;
		x_d     = x_q;
		y_d     = y_q;
		pc_d    = pc_q;
		op_d    = op_q;
		lo_d    = lo_q;
		cyc_d   = cyc_q;
		mem_req = '0;
		alu_in  = '0;
		case (state_q)
			clse_pkg::ST_IDLE: begin
				if (start) begin
					cyc_d   = 3'd0;
					state_d = clse_pkg::ST_DONE;
					case (req_type)
						clse_pkg::REQ_WRITE: begin
							mem_req.we    = 1'b1;
							mem_req.addr  = address;
							mem_req.wdata = write_byte;
						end
						clse_pkg::REQ_SET_PC: begin
							pc_d = address;
						end
						clse_pkg::REQ_EXEC: begin
							mem_req.addr = pc_q;
							alu_in.a     = pc_q;
							alu_in.b     = 16'd1;
							pc_d         = alu_out.sum;
							state_d      = clse_pkg::ST_FETCH_OP;
						end
						default: begin
						end
					endcase
				end
			end
			clse_pkg::ST_FETCH_OP: begin
				op_d  = rdata;
				cyc_d = 3'd2;
				if (rdata inside {clse_pkg::OP_LDA_IMM, clse_pkg::OP_LDA_ZP,
						clse_pkg::OP_LDA_ZPX, clse_pkg::OP_LDA_ABS, clse_pkg::OP_LDA_ABX,
						clse_pkg::OP_LDA_ABY, clse_pkg::OP_LDA_INX, clse_pkg::OP_LDA_INY,
						clse_pkg::OP_LDX_IMM, clse_pkg::OP_LDY_IMM, clse_pkg::OP_STA_ZP,
						clse_pkg::OP_STX_ZP, clse_pkg::OP_STY_ZP}) begin
					mem_req.addr = pc_q;
					alu_in.a     = pc_q;
					alu_in.b     = 16'd1;
					pc_d         = alu_out.sum;
					state_d      = clse_pkg::ST_OPER1;
				end else begin
					// Unsupported opcodes only step past the opcode byte.
					state_d = clse_pkg::ST_DONE;
				end
			end
			clse_pkg::ST_OPER1: begin
				lo_d    = rdata;
				state_d = clse_pkg::ST_DONE;
				case (op_q)
					clse_pkg::OP_LDA_IMM: acc_d = rdata;
					clse_pkg::OP_LDX_IMM: x_d = rdata;
					clse_pkg::OP_LDY_IMM: y_d = rdata;
					clse_pkg::OP_LDA_ZP: begin
						mem_req.addr = {8'h00, rdata};
						cyc_d        = 3'd3;
						state_d      = clse_pkg::ST_LOAD;
					end
					clse_pkg::OP_LDA_ZPX: begin
						alu_in.a     = {8'h00, rdata};
						alu_in.b     = {8'h00, x_q};
						mem_req.addr = {8'h00, alu_out.sum[7:0]};
						cyc_d        = 3'd4;
						state_d      = clse_pkg::ST_LOAD;
					end
					clse_pkg::OP_LDA_ABS, clse_pkg::OP_LDA_ABX, clse_pkg::OP_LDA_ABY: begin
						mem_req.addr = pc_q;
						alu_in.a     = pc_q;
						alu_in.b     = 16'd1;
						pc_d         = alu_out.sum;
						state_d      = clse_pkg::ST_OPER2;
					end
					clse_pkg::OP_LDA_INX: begin
						alu_in.a     = {8'h00, rdata};
						alu_in.b     = {8'h00, x_q};
						mem_req.addr = {8'h00, alu_out.sum[7:0]};
						lo_d         = alu_out.sum[7:0];
						cyc_d        = 3'd6;
						state_d      = clse_pkg::ST_PTR_HI;
					end
					clse_pkg::OP_LDA_INY: begin
						mem_req.addr = {8'h00, rdata};
						cyc_d        = 3'd5;
						state_d      = clse_pkg::ST_PTR_HI;
					end
					clse_pkg::OP_STA_ZP, clse_pkg::OP_STX_ZP, clse_pkg::OP_STY_ZP: begin
						mem_req.we   = 1'b1;
						mem_req.addr = {8'h00, rdata};
						cyc_d        = 3'd3;
						case (op_q)
							clse_pkg::OP_STA_ZP: mem_req.wdata = acc_q;
							clse_pkg::OP_STX_ZP: mem_req.wdata = x_q;
							default:             mem_req.wdata = y_q;
						endcase
					end
					default: begin
					end
				endcase
			end
			clse_pkg::ST_OPER2: begin
				state_d = clse_pkg::ST_LOAD;
				if (op_q == clse_pkg::OP_LDA_ABS) begin
					mem_req.addr = {rdata, lo_q};
					cyc_d        = 3'd4;
				end else begin
					alu_in.a     = {rdata, lo_q};
					alu_in.b     = {8'h00, (op_q == clse_pkg::OP_LDA_ABX) ? x_q : y_q};
					mem_req.addr = alu_out.sum;
					cyc_d        = 3'd4 + {2'b00, alu_out.page_cross};
				end
			end
			clse_pkg::ST_PTR_HI: begin
				// Second pointer byte wraps inside page zero.
				alu_in.a     = {8'h00, lo_q};
				alu_in.b     = 16'd1;
				mem_req.addr = {8'h00, alu_out.sum[7:0]};
				lo_d         = rdata;
				state_d      = clse_pkg::ST_PTR_END;
			end
			clse_pkg::ST_PTR_END: begin
				state_d = clse_pkg::ST_LOAD;
				if (op_q == clse_pkg::OP_LDA_INX) begin
					mem_req.addr = {rdata, lo_q};
				end else begin
					alu_in.a     = {rdata, lo_q};
					alu_in.b     = {8'h00, y_q};
					mem_req.addr = alu_out.sum;
					cyc_d        = cyc_q + {2'b00, alu_out.page_cross};
				end
			end
			clse_pkg::ST_LOAD: begin
				acc_d   = rdata;
				state_d = clse_pkg::ST_DONE;
			end
			clse_pkg::ST_DONE: begin
				if (res_taken) begin
					state_d = clse_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = clse_pkg::ST_IDLE;
			end
		endcase
	end

	assign stat.idle      = (state_q == clse_pkg::ST_IDLE);
	assign stat.res_valid = (state_q == clse_pkg::ST_DONE);

	assign result.cycles = cyc_q;
	assign result.acc    = acc_q;
	assign result.x      = x_q;
	assign result.y      = y_q;
	assign result.pc     = pc_q;

endmodule

// ===== sv/cpu_load_store_subset_executor_unit.sv =====
// Top level of the load/store subset executor: stream ports, memory, sequencer, result register.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+----------------------------------------------
//  s_*      | in        | s_tvalid, s_tready | s_tuser: req_type; s_tdata: address, write_byte
//  m_*      | out       | m_tvalid, m_tready | m_tdata: cycles_taken, accumulator, index_x,
//           |           |                    |          index_y, program_counter
//
// A memory write, a program counter load or an unknown request passes from the accepted beat
// through the final sequencer state to the result register. An executed instruction steps
// through the single memory port: one read per cycle for opcode, operands, pointer bytes and
// data, plus the final hand-off to the result register.
// Reset is asynchronous and clears the sequencer, the registers A, X, Y and PC and the result
// valid flag; the memory holds no reset value. A full result register that is not taken holds
// the sequencer in its final state, and no new beat is accepted until the sequencer is idle.
module cpu_load_store_subset_executor_unit #(
	parameter int MEM_ADDR_BITS = clse_pkg::MEM_ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_byte
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // [2:0] cycles_taken, [10:3] accumulator,
	                               // [18:11] index_x, [26:19] index_y,
	                               // [42:27] program_counter, [47:43] zero
);

	localparam int MemDepth = 1 << MEM_ADDR_BITS;

	clse_pkg::mem_req_t  mem_req;
	clse_pkg::seq_stat_t stat;
	clse_pkg::result_t   result;
	clse_pkg::result_t   out_q;

	logic       in_beat;
	logic       out_load;
	logic       out_valid_q;
	logic [7:0] rdata;

	// An input beat is taken only while the sequencer waits for work.
	assign s_tready = stat.idle;
	assign in_beat  = s_tvalid && s_tready;

	// The finished result moves into the output register once that register is free or
	// being emptied in the same cycle.
	assign out_load = stat.res_valid && (!out_valid_q || m_tready);

	clse_ram #(
		.WIDTH (8),
		.DEPTH (MemDepth)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.addr  (mem_req.addr[MEM_ADDR_BITS-1:0]),
		.wdata (mem_req.wdata),
		.rdata (rdata)
	);

	clse_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_beat),
		.req_type   (s_tuser),
		.address    (s_tdata[15:0]),
		.write_byte (s_tdata[23:16]),
		.rdata      (rdata),
		.res_taken  (out_load),
		.mem_req    (mem_req),
		.stat       (stat),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, out_q.pc, out_q.y, out_q.x, out_q.acc, out_q.cycles};

	// An accepted beat always moves the sequencer out of its idle state.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_tready)
		else $error("sequencer stayed idle after an accepted beat");

	// Idle and result-pending are exclusive sequencer conditions.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.idle && stat.res_valid))
		else $error("sequencer idle while a result is pending");

	// A pending result that could not be moved is still pending next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_valid && !out_load |=> stat.res_valid)
		else $error("pending result dropped");

	// The cycles_taken field never holds the values 1 or 7.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_q.cycles != 3'd1) && (out_q.cycles != 3'd7))
		else $error("impossible cycle count");

endmodule
